/* sv/aprd_pkg.sv */
// Shared types and constants for the AIS position report decoder.
package aprd_pkg;

	localparam int STORE_DEPTH = 23;
	localparam int SEXTET_W    = 6;
	localparam int BIT_LEN     = STORE_DEPTH * SEXTET_W;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [5:0] MT_POS_A1 = 6'd1;
	localparam logic [5:0] MT_POS_A2 = 6'd2;
	localparam logic [5:0] MT_POS_A3 = 6'd3;
	localparam logic [5:0] MT_POS_B  = 6'd18;

	localparam logic [9:0]  NA_SOG = 10'd1023;
	localparam logic [27:0] NA_LON = 28'h6791AC0;
	localparam logic [26:0] NA_LAT = 27'h3412140;
	localparam logic [11:0] NA_COG = 12'd3600;
	localparam logic [8:0]  NA_HDG = 9'd511;

	localparam logic [7:0] ARMOR_LO_MIN = 8'd48;
	localparam logic [7:0] ARMOR_LO_MAX = 8'd87;
	localparam logic [7:0] ARMOR_HI_MIN = 8'd96;
	localparam logic [7:0] ARMOR_HI_MAX = 8'd119;
	localparam logic [7:0] ARMOR_HI_OFS = 8'd56;

	// bits[BIT_LEN-1] is message bit 0
	typedef struct packed {
		logic               class_b;
		logic [BIT_LEN-1:0] bits;
	} job_t;

endpackage

/* sv/aprd_front.sv */
// Front end: de-armors characters, fills the sextet store, classifies finished reports.
module aprd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         symbol,
	input  logic               last,
	input  logic               symbol_valid,
	output logic               symbol_ready,
	input  logic               full,
	output logic               push,
	output aprd_pkg::job_t     push_job
);

	logic [aprd_pkg::SEXTET_W-1:0] sextet_q [aprd_pkg::STORE_DEPTH];
	logic [aprd_pkg::CNT_W-1:0]    cnt_q;
	logic [aprd_pkg::SEXTET_W-1:0] sx;
	logic [aprd_pkg::BIT_LEN-1:0]  snap;
	logic [5:0]                    snap_type;
	logic [29:0]                   snap_mmsi;
	logic                          accept;
	logic                          known;
	logic                          is_b;

	function automatic logic [5:0] dearmor(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= aprd_pkg::ARMOR_LO_MIN && c <= aprd_pkg::ARMOR_LO_MAX)
			d = c - aprd_pkg::ARMOR_LO_MIN;
		else if (c >= aprd_pkg::ARMOR_HI_MIN && c <= aprd_pkg::ARMOR_HI_MAX)
			d = c - aprd_pkg::ARMOR_HI_OFS;
		return d[5:0];
	endfunction

	assign sx           = dearmor(symbol);
	assign symbol_ready = !full;
	assign accept       = symbol_valid && symbol_ready;

	always_comb begin
		for (int i = 0; i < aprd_pkg::STORE_DEPTH; i++) begin
			if (cnt_q == aprd_pkg::CNT_W'(i))
				snap[aprd_pkg::BIT_LEN-1-i*aprd_pkg::SEXTET_W -: aprd_pkg::SEXTET_W] = sx;
			else
				snap[aprd_pkg::BIT_LEN-1-i*aprd_pkg::SEXTET_W -: aprd_pkg::SEXTET_W] =
					sextet_q[i];
		end
	end

	assign snap_type = snap[aprd_pkg::BIT_LEN-1 -: 6];
	assign snap_mmsi = snap[aprd_pkg::BIT_LEN-1-8 -: 30];

	always_comb begin
		known = 1'b0;
		is_b  = 1'b0;
		unique case (snap_type) inside
			aprd_pkg::MT_POS_A1, aprd_pkg::MT_POS_A2, aprd_pkg::MT_POS_A3: begin
				known = 1'b1;
			end
			aprd_pkg::MT_POS_B: begin
				known = 1'b1;
				is_b  = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign push             = accept && last && known && (snap_mmsi != 30'd0);
	assign push_job.class_b = is_b;
	assign push_job.bits    = snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < aprd_pkg::STORE_DEPTH; i++)
				sextet_q[i] <= '0;
		end else if (accept) begin
			if (last) begin
				cnt_q <= '0;
				for (int i = 0; i < aprd_pkg::STORE_DEPTH; i++)
					sextet_q[i] <= '0;
			end else if (cnt_q < aprd_pkg::CNT_W'(aprd_pkg::STORE_DEPTH)) begin
				sextet_q[cnt_q[aprd_pkg::IDX_W-1:0]] <= sx;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

/* sv/aprd_queue.sv */
// Two-entry job queue between front end and field decoder.
module aprd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aprd_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output aprd_pkg::job_t head
);

	aprd_pkg::job_t              mem_q [aprd_pkg::QUEUE_DEPTH];
	logic [aprd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [aprd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [aprd_pkg::QCNT_W-1:0] count_q;

	assign full  = count_q == aprd_pkg::QCNT_W'(aprd_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= aprd_pkg::QCNT_W'(aprd_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

/* sv/aprd_back.sv */
// Back end: extracts report fields at the type's offsets into the output register.
module aprd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  aprd_pkg::job_t     head,
	output logic               pop,
	output logic               report_valid,
	input  logic               report_ready,
	output logic [5:0]         msg_type,
	output logic [29:0]        mmsi,
	output logic [9:0]         sog,
	output logic               sog_ok,
	output logic signed [27:0] lon,
	output logic               lon_ok,
	output logic signed [26:0] lat,
	output logic               lat_ok,
	output logic [11:0]        cog,
	output logic               cog_ok,
	output logic [8:0]         heading,
	output logic               heading_ok
);

	localparam int TOP    = aprd_pkg::BIT_LEN - 1;
	localparam int BASE_A = 50;
	localparam int BASE_B = 46;

	logic        valid_q;
	logic [5:0]  type_q;
	logic [29:0] mmsi_q;
	logic [9:0]  sog_q;
	logic [27:0] lon_q;
	logic [26:0] lat_q;
	logic [11:0] cog_q;
	logic [8:0]  hdg_q;
	logic [9:0]  f_sog;
	logic [27:0] f_lon;
	logic [26:0] f_lat;
	logic [11:0] f_cog;
	logic [8:0]  f_hdg;

	always_comb begin
		if (head.class_b) begin
			f_sog = head.bits[TOP-BASE_B -: 10];
			f_lon = head.bits[TOP-BASE_B-11 -: 28];
			f_lat = head.bits[TOP-BASE_B-39 -: 27];
			f_cog = head.bits[TOP-BASE_B-66 -: 12];
			f_hdg = head.bits[TOP-BASE_B-78 -: 9];
		end else begin
			f_sog = head.bits[TOP-BASE_A -: 10];
			f_lon = head.bits[TOP-BASE_A-11 -: 28];
			f_lat = head.bits[TOP-BASE_A-39 -: 27];
			f_cog = head.bits[TOP-BASE_A-66 -: 12];
			f_hdg = head.bits[TOP-BASE_A-78 -: 9];
		end
	end

	assign pop = !empty && (!valid_q || report_ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			type_q <= head.bits[TOP -: 6];
			mmsi_q <= head.bits[TOP-8 -: 30];
			sog_q  <= f_sog;
			lon_q  <= f_lon;
			lat_q  <= f_lat;
			cog_q  <= f_cog;
			hdg_q  <= f_hdg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (report_ready)
			valid_q <= 1'b0;
	end

	assign report_valid = valid_q;
	assign msg_type     = type_q;
	assign mmsi         = mmsi_q;
	assign sog          = sog_q;
	assign sog_ok       = sog_q != aprd_pkg::NA_SOG;
	assign lon          = lon_q;
	assign lon_ok       = lon_q != aprd_pkg::NA_LON;
	assign lat          = lat_q;
	assign lat_ok       = lat_q != aprd_pkg::NA_LAT;
	assign cog          = cog_q;
	assign cog_ok       = cog_q != aprd_pkg::NA_COG;
	assign heading      = hdg_q;
	assign heading_ok   = hdg_q != aprd_pkg::NA_HDG;

endmodule

/* sv/ais_position_report_decoder.sv */
// Top level of the AIS position report decoder.
// Throughput: one character per cycle unless the job queue is full; character storing and
// report decoding overlap. A report enters the job queue on the edge that accepts its last
// character, and moves from the queue into the output register once that register is free.
// The two-entry job queue absorbs output stalls; symbol_ready drops only while it is full.
// Reset (arst_n low, asynchronous) clears the sextet store, count, queue and output valid.
module ais_position_report_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         symbol,
	input  logic               last,
	input  logic               symbol_valid,
	output logic               symbol_ready,
	output logic               report_valid,
	input  logic               report_ready,
	output logic [5:0]         msg_type,
	output logic [29:0]        mmsi,
	output logic [9:0]         sog,
	output logic               sog_ok,
	output logic signed [27:0] lon,
	output logic               lon_ok,
	output logic signed [26:0] lat,
	output logic               lat_ok,
	output logic [11:0]        cog,
	output logic               cog_ok,
	output logic [8:0]         heading,
	output logic               heading_ok
);

	aprd_pkg::job_t push_job;
	aprd_pkg::job_t head;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	aprd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.symbol       (symbol),
		.last         (last),
		.symbol_valid (symbol_valid),
		.symbol_ready (symbol_ready),
		.full         (full),
		.push         (push),
		.push_job     (push_job)
	);

	aprd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	aprd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.msg_type     (msg_type),
		.mmsi         (mmsi),
		.sog          (sog),
		.sog_ok       (sog_ok),
		.lon          (lon),
		.lon_ok       (lon_ok),
		.lat          (lat),
		.lat_ok       (lat_ok),
		.cog          (cog),
		.cog_ok       (cog_ok),
		.heading      (heading),
		.heading_ok   (heading_ok)
	);

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the AIS position report decoder: random and directed payloads.
module tb;

	localparam int CLASS_A_BASE = 50;
	localparam int CLASS_B_BASE = 46;
	localparam int MSG_BITS     = 168;
	localparam int MSG_CHARS    = MSG_BITS / aprd_pkg::SEXTET_W;
	localparam int RANDOM_ITEMS = 1400;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] sym;
		logic       lst;
	} char_t;

	typedef struct packed {
		logic [5:0]  mt;
		logic [29:0] id;
		logic [9:0]  spd;
		logic        spd_ok;
		logic [27:0] lo;
		logic        lo_ok;
		logic [26:0] la;
		logic        la_ok;
		logic [11:0] crs;
		logic        crs_ok;
		logic [8:0]  hdg;
		logic        hdg_ok;
	} position_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic [7:0]         symbol = '0;
	logic               last = 1'b0;
	logic               symbol_valid = 1'b0;
	logic               symbol_ready;
	logic               report_valid;
	logic               report_ready = 1'b0;
	logic [5:0]         msg_type;
	logic [29:0]        mmsi;
	logic [9:0]         sog;
	logic               sog_ok;
	logic signed [27:0] lon;
	logic               lon_ok;
	logic signed [26:0] lat;
	logic               lat_ok;
	logic [11:0]        cog;
	logic               cog_ok;
	logic [8:0]         heading;
	logic               heading_ok;

	char_t            tx_chars[$];
	position_report_t expected_reports[$];
	logic [5:0]       rx_store[aprd_pkg::STORE_DEPTH];
	int               rx_count = 0;
	bit               failed = 1'b0;
	int               burst_left = 1;
	int               gap_left = 0;
	int               idle_cycles = 0;
	int               stall_window = 0;
	int               stall_mode = 0;

	ais_position_report_decoder dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [5:0] unarmor(logic [7:0] ch);
		if (ch >= aprd_pkg::ARMOR_LO_MIN && ch <= aprd_pkg::ARMOR_LO_MAX)
			return 6'(ch - aprd_pkg::ARMOR_LO_MIN);
		if (ch >= aprd_pkg::ARMOR_HI_MIN && ch <= aprd_pkg::ARMOR_HI_MAX)
			return 6'(ch - aprd_pkg::ARMOR_HI_OFS);
		return '0;
	endfunction

	function automatic logic [31:0] take_bits(logic [aprd_pkg::BIT_LEN-1:0] v, int pos,
			int len);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < len; i++)
			r = {r[30:0], v[aprd_pkg::BIT_LEN-1-pos-i]};
		return r;
	endfunction

	// Store one character; on the final one decode the position report and clear.
	task automatic absorb_symbol(input logic [7:0] ch, input logic lst);
		logic [aprd_pkg::BIT_LEN-1:0] flat;
		logic [5:0]                   t;
		logic [29:0]                  id;
		int                           base;
		position_report_t             r;
		if (rx_count < aprd_pkg::STORE_DEPTH) begin
			rx_store[rx_count] = unarmor(ch);
			rx_count++;
		end
		if (lst) begin
			for (int i = 0; i < aprd_pkg::STORE_DEPTH; i++)
				flat[aprd_pkg::BIT_LEN-1-aprd_pkg::SEXTET_W*i -: aprd_pkg::SEXTET_W] =
					rx_store[i];
			t  = 6'(take_bits(flat, 0, 6));
			id = 30'(take_bits(flat, 8, 30));
			if (t == aprd_pkg::MT_POS_A1 || t == aprd_pkg::MT_POS_A2 ||
					t == aprd_pkg::MT_POS_A3)
				base = CLASS_A_BASE;
			else if (t == aprd_pkg::MT_POS_B)
				base = CLASS_B_BASE;
			else
				base = 0;
			if (base != 0 && id != '0) begin
				r.mt     = t;
				r.id     = id;
				r.spd    = 10'(take_bits(flat, base, 10));
				r.spd_ok = (r.spd != aprd_pkg::NA_SOG);
				r.lo     = 28'(take_bits(flat, base + 11, 28));
				r.lo_ok  = (r.lo != aprd_pkg::NA_LON);
				r.la     = 27'(take_bits(flat, base + 39, 27));
				r.la_ok  = (r.la != aprd_pkg::NA_LAT);
				r.crs    = 12'(take_bits(flat, base + 66, 12));
				r.crs_ok = (r.crs != aprd_pkg::NA_COG);
				r.hdg    = 9'(take_bits(flat, base + 78, 9));
				r.hdg_ok = (r.hdg != aprd_pkg::NA_HDG);
				expected_reports.push_back(r);
			end
			for (int i = 0; i < aprd_pkg::STORE_DEPTH; i++)
				rx_store[i] = '0;
			rx_count = 0;
		end
	endtask

	// Stimulus encoding
	function automatic logic [MSG_BITS-1:0] put_bits(logic [MSG_BITS-1:0] v, int pos, int len,
			logic [31:0] val);
		for (int i = 0; i < len; i++)
			v[MSG_BITS-1-pos-i] = val[len-1-i];
		return v;
	endfunction

	function automatic logic [7:0] bad_char();
		case ($urandom_range(0, 2))
			0: return 8'($urandom_range(0, 47));
			1: return 8'($urandom_range(88, 95));
			default: return 8'($urandom_range(120, 255));
		endcase
	endfunction

	function automatic logic [7:0] armor(logic [5:0] v, bit alt_zero);
		if (v == '0 && alt_zero)
			return bad_char();
		return (v < 6'd40) ? 8'(v) + aprd_pkg::ARMOR_LO_MIN : 8'(v) + aprd_pkg::ARMOR_HI_OFS;
	endfunction

	task automatic queue_report(input logic [5:0] t, input logic [29:0] id, input logic [9:0] spd,
			input logic [27:0] lo, input logic [26:0] la, input logic [11:0] crs,
			input logic [8:0] hdg, input int nchars, input bit alt_zero);
		logic [MSG_BITS-1:0] bits;
		int                  base;
		char_t               c;
		for (int i = 0; i < MSG_BITS / 32 + 1; i++)
			bits = put_bits(bits, i * 32 < MSG_BITS - 32 ? i * 32 : MSG_BITS - 32, 32, $urandom());
		base = (t == aprd_pkg::MT_POS_B) ? CLASS_B_BASE : CLASS_A_BASE;
		bits = put_bits(bits, 0, 6, 32'(t));
		bits = put_bits(bits, 8, 30, 32'(id));
		bits = put_bits(bits, base, 10, 32'(spd));
		bits = put_bits(bits, base + 11, 28, 32'(lo));
		bits = put_bits(bits, base + 39, 27, 32'(la));
		bits = put_bits(bits, base + 66, 12, 32'(crs));
		bits = put_bits(bits, base + 78, 9, 32'(hdg));
		for (int k = 0; k < nchars; k++) begin
			if (k < MSG_CHARS)
				c.sym = armor(bits[MSG_BITS-1-aprd_pkg::SEXTET_W*k -: aprd_pkg::SEXTET_W],
					alt_zero);
			else
				c.sym = 8'($urandom_range(0, 255));
			c.lst = (k == nchars - 1);
			tx_chars.push_back(c);
		end
	endtask

	function automatic logic [31:0] pick_value(int width, logic [31:0] na);
		logic [31:0] mask;
		mask = (32'h1 << width) - 1;
		case ($urandom_range(0, 9))
			0: return na;
			1: return '0;
			2: return mask;
			3: return 32'h1 << (width - 1);
			4: return (32'h1 << (width - 1)) - 1;
			default: return $urandom() & mask;
		endcase
	endfunction

	task automatic queue_random_message();
		logic [5:0]  t;
		logic [29:0] id;
		int          n;
		char_t       c;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 30);
			for (int k = 0; k < n; k++) begin
				c.sym = 8'($urandom_range(0, 255));
				c.lst = (k == n - 1);
				tx_chars.push_back(c);
			end
		end else begin
			case ($urandom_range(0, 9))
				0, 1: t = aprd_pkg::MT_POS_A1;
				2, 3: t = aprd_pkg::MT_POS_A2;
				4, 5: t = aprd_pkg::MT_POS_A3;
				6, 7: t = aprd_pkg::MT_POS_B;
				default: t = 6'($urandom_range(0, 63));
			endcase
			case ($urandom_range(0, 19))
				0: id = '0;
				1: id = '1;
				2: id = 30'd1;
				default: id = 30'($urandom());
			endcase
			case ($urandom_range(0, 9))
				0: n = $urandom_range(1, 22);
				1, 2: n = $urandom_range(23, 27);
				3: n = $urandom_range(29, 34);
				default: n = MSG_CHARS;
			endcase
			queue_report(t, id, 10'(pick_value(10, 32'(aprd_pkg::NA_SOG))),
				28'(pick_value(28, 32'(aprd_pkg::NA_LON))),
				27'(pick_value(27, 32'(aprd_pkg::NA_LAT))),
				12'(pick_value(12, 32'(aprd_pkg::NA_COG))),
				9'(pick_value(9, 32'(aprd_pkg::NA_HDG))),
				n, 1'($urandom_range(0, 1)));
		end
	endtask

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin : driver
		char_t nxt;
		if (!arst_n) begin
			symbol_valid <= 1'b0;
			symbol       <= '0;
			last         <= 1'b0;
		end else begin
			if (symbol_valid && symbol_ready)
				absorb_symbol(symbol, last);
			if (!symbol_valid || symbol_ready) begin
				if (gap_left > 0 || tx_chars.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					symbol_valid <= 1'b0;
				end else begin
					nxt = tx_chars.pop_front();
					symbol       <= nxt.sym;
					last         <= nxt.lst;
					symbol_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						case ($urandom_range(0, 9))
							0, 1, 2: gap_left = 0;
							3: gap_left = $urandom_range(15, 40);
							default: gap_left = $urandom_range(1, 6);
						endcase
					end
				end
			end
		end
	end

	// Receiver: stall mode changes every window
	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			report_ready <= 1'b0;
		end else begin
			if (stall_window == 0) begin
				stall_window = $urandom_range(16, 80);
				stall_mode   = $urandom_range(0, 3);
			end
			stall_window--;
			case (stall_mode)
				0: report_ready <= 1'b1;
				1: report_ready <= 1'($urandom_range(0, 1));
				2: report_ready <= ($urandom_range(0, 7) == 0);
				default: report_ready <= (stall_window % 5 != 0);
			endcase
		end
	end

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin : monitor
		position_report_t want;
		if (arst_n && report_valid && report_ready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual type %0d mmsi %0h",
					$time, msg_type, mmsi);
				failed = 1'b1;
			end else begin
				want = expected_reports.pop_front();
				check_field("msg_type", 64'(want.mt), 64'(msg_type));
				check_field("mmsi", 64'(want.id), 64'(mmsi));
				check_field("sog", 64'(want.spd), 64'(sog));
				check_field("sog_ok", 64'(want.spd_ok), 64'(sog_ok));
				check_field("lon", 64'(want.lo), 64'($unsigned(lon)));
				check_field("lon_ok", 64'(want.lo_ok), 64'(lon_ok));
				check_field("lat", 64'(want.la), 64'($unsigned(lat)));
				check_field("lat_ok", 64'(want.la_ok), 64'(lat_ok));
				check_field("cog", 64'(want.crs), 64'(cog));
				check_field("cog_ok", 64'(want.crs_ok), 64'(cog_ok));
				check_field("heading", 64'(want.hdg), 64'(heading));
				check_field("heading_ok", 64'(want.hdg_ok), 64'(heading_ok));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((symbol_valid && symbol_ready) || (report_valid && report_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		char_t c;
		int    directed;
		for (int i = 0; i < aprd_pkg::STORE_DEPTH; i++)
			rx_store[i] = '0;
		// last alone, invalid character
		c.sym = 8'hFF;
		c.lst = 1'b1;
		tx_chars.push_back(c);
		// last alone, type 1 with zero identity
		c.sym = 8'd49;
		tx_chars.push_back(c);
		// long class A payload, field maxima
		queue_report(aprd_pkg::MT_POS_A1, '1, 10'd1022, 28'h7FFFFFF, 27'h3FFFFFF, 12'hFFF,
			9'd510, MSG_CHARS, 1'b0);
		// class B, all fields not available
		queue_report(aprd_pkg::MT_POS_B, 30'd1, aprd_pkg::NA_SOG, aprd_pkg::NA_LON,
			aprd_pkg::NA_LAT, aprd_pkg::NA_COG, aprd_pkg::NA_HDG, aprd_pkg::STORE_DEPTH, 1'b1);
		// short payload, missing bits read as zero
		queue_report(aprd_pkg::MT_POS_A2, 30'h2AAAAAAA, '0, 28'h8000000, 27'h4000000, '0, '0,
			9, 1'b0);
		queue_report(aprd_pkg::MT_POS_A3, 30'h15555555, 10'd1, 28'h8000000, 27'h4000000,
			aprd_pkg::NA_COG, '0, MSG_CHARS, 1'b1);
		// other type with nonzero identity
		queue_report(6'd5, 30'h12345, '0, '0, '0, '0, '0, MSG_CHARS, 1'b0);
		directed = tx_chars.size();
		while (tx_chars.size() < directed + RANDOM_ITEMS)
			queue_random_message();

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (tx_chars.size() != 0 || symbol_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0)
			$display("%0t: %0d expected transactions never arrived", $time,
				expected_reports.size());
		if (!failed && expected_reports.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
